// ===== rtl/npd_pkg.sv =====
// Shared types and constants for the neighbor pulse period decoder.
// Used by every module of the block; no dependencies.
package npd_pkg;

  localparam int FACE_COUNT   = 6;
  localparam int FACE_W       = 3;
  localparam int LEVEL_W      = 6;
  localparam int OUT_FACES    = 6;
  localparam int STATE_SLOTS  = (FACE_COUNT > OUT_FACES) ? FACE_COUNT : OUT_FACES;
  localparam int RING_DEPTH   = 4;
  localparam int PTR_W        = 2;
  localparam int RING_ENTRIES = FACE_COUNT * RING_DEPTH;
  localparam int ADDR_W       = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
  localparam int STAMP_W      = 32;
  localparam int FSTATE_W     = 5;
  localparam int COUNT_W      = 4;
  localparam int RULE_W       = 7;
  localparam int BYTE_W       = 8;
  localparam int CFG_IDX_W    = 3;

  localparam logic [RULE_W-1:0] BIRTH_RESET   = 7'd12;
  localparam logic [RULE_W-1:0] DEATH_RESET   = 7'd115;
  localparam logic [BYTE_W-1:0] NSTATES_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] STALE_RESET   = 8'd100;
  localparam logic [BYTE_W-1:0] RAPID_RESET   = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIRTH   = 3'd0,
    REG_DEATH   = 3'd1,
    REG_NSTATES = 3'd2,
    REG_STALE   = 3'd3,
    REG_RAPID   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [STAMP_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ring_req_t;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] age;
    logic [BYTE_W-1:0] modulus;
  } age_req_t;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] result;
  } age_rsp_t;

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [FACE_W-1:0] f,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'({f, p});
  endfunction

endpackage

// ===== rtl/npd_ring_mem.sv =====
// Stamp ring storage: one write and one registered read port per cycle.
// Per-entry valid bits make unwritten entries read as zero. Uses npd_pkg.
module npd_ring_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  npd_pkg::ring_req_t          req,
  output logic [npd_pkg::STAMP_W-1:0] rdata
);
  import npd_pkg::*;

  logic [STAMP_W-1:0]      mem [RING_ENTRIES];
  logic [RING_ENTRIES-1:0] vld;
  logic [STAMP_W-1:0]      rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      rd_vld <= vld[req.raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

// ===== rtl/npd_age_mod.sv =====
// Tile age wrap: (age + 1) mod num_states, zero modulus meaning 256.
// Restoring remainder, one bit per cycle. Uses npd_pkg.
module npd_age_mod (
  input  logic              clk,
  input  logic              rst,
  input  npd_pkg::age_req_t req,
  output npd_pkg::age_rsp_t rsp
);
  import npd_pkg::*;

  logic         run;
  logic [3:0]   cnt;
  logic [8:0]   num;
  logic [8:0]   rem;
  logic [8:0]   div;
  logic [9:0]   trial;
  logic [8:0]   rem_next;

  assign trial    = {rem, num[8]};
  assign rem_next = (trial >= {1'b0, div}) ? 9'(trial - {1'b0, div}) : trial[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      run <= 1'b1;
      cnt <= 4'd9;
      num <= {1'b0, req.age} + 9'd1;
      rem <= '0;
      div <= (req.modulus == '0) ? 9'd256 : {1'b0, req.modulus};
    end else if (run) begin
      if (cnt != '0) begin
        rem <= rem_next;
        num <= {num[7:0], 1'b0};
        cnt <= cnt - 4'd1;
      end else begin
        run <= 1'b0;
      end
    end
  end

  assign rsp.done   = run && (cnt == '0);
  assign rsp.result = rem[BYTE_W-1:0];

endmodule

// ===== rtl/neighbor_pulse_period_decoder_top.sv =====
// Top level of the neighbor pulse period decoder: sequencer, edge handling,
// period decode and tile rule. Uses npd_pkg, npd_ring_mem and npd_age_mod.
//
// One input word is one tick. The block takes one word at a time: in_ready is
// high only while idle, and drops for the whole tick. A tick takes an edge
// step for each face and a read step between faces; with evaluate set, each
// face also gets decode steps and a match step, and a live tile that ages
// then runs the bit-serial age wrap. During decode the stamp memory is read
// one stamp per cycle through a shared 32-bit subtract/compare unit. The
// result sits in an output register, so ready returns as soon as the result is
// loaded even if the consumer has not yet taken it; the next result then waits
// until the output register is free. No clearing pass after reset. Config
// writes are always accepted.
module neighbor_pulse_period_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [npd_pkg::LEVEL_W-1:0]    face_levels,
  input  logic                           evaluate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           click,
  output logic                           program_request,
  output logic [npd_pkg::FACE_W-1:0]     program_face,
  output logic [npd_pkg::FSTATE_W-1:0]   face0_state,
  output logic [npd_pkg::FSTATE_W-1:0]   face1_state,
  output logic [npd_pkg::FSTATE_W-1:0]   face2_state,
  output logic [npd_pkg::FSTATE_W-1:0]   face3_state,
  output logic [npd_pkg::FSTATE_W-1:0]   face4_state,
  output logic [npd_pkg::FSTATE_W-1:0]   face5_state,
  output logic [2:0]                     neighbors_on,
  output logic [npd_pkg::BYTE_W-1:0]     tile_age,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [npd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npd_pkg::BYTE_W-1:0]     cfg_data
);
  import npd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EDGE, S_DEC, S_MATCH, S_RULE, S_AGE, S_DONE
  } state_t;

  state_t state;

  logic [RULE_W-1:0]   birth_rules;
  logic [RULE_W-1:0]   death_rules;
  logic [BYTE_W-1:0]   num_states;
  logic [BYTE_W-1:0]   stale_limit;
  logic [BYTE_W-1:0]   rapid_limit;

  logic [STAMP_W-1:0]  tick;
  logic [LEVEL_W-1:0]  prev_levels;
  logic [LEVEL_W-1:0]  rising;
  logic                eval_q;
  logic [PTR_W-1:0]    ring_ptr  [FACE_COUNT];
  logic [BYTE_W-1:0]   rapid_cnt [FACE_COUNT];
  logic [BYTE_W-1:0]   tile;

  logic [FACE_W-1:0]   fidx;
  logic [2:0]          k;
  logic [STAMP_W-1:0]  prev_stamp;
  logic                stale;
  logic [FSTATE_W-1:0] gap [3];
  logic [FSTATE_W-1:0] fstate [STATE_SLOTS];
  logic [COUNT_W-1:0]  on_cnt;
  logic                click_acc;
  logic                req_acc;
  logic [FACE_W-1:0]   req_face;

  ring_req_t           ring_req;
  logic [STAMP_W-1:0]  rdata;
  age_req_t            age_req;
  age_rsp_t            age_rsp;

  logic [(1<<FACE_W)-1:0] rise_ext;
  logic                rise_cur;
  logic [PTR_W-1:0]    ptr_cur;
  logic [STAMP_W-1:0]  sub_a;
  logic [STAMP_W-1:0]  diff;
  logic                over;
  logic                rapid_hit;
  logic [BYTE_W-1:0]   rc_inc;
  logic [FSTATE_W-1:0] match;
  logic                rule_ok;
  logic                last_face;

  npd_ring_mem u_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (ring_req),
    .rdata (rdata)
  );

  npd_age_mod u_age (
    .clk (clk),
    .rst (rst),
    .req (age_req),
    .rsp (age_rsp)
  );

  // shared subtract/compare unit
  assign rise_ext  = (1 << FACE_W)'(rising);
  assign rise_cur  = rise_ext[fidx];
  assign ptr_cur   = ring_ptr[fidx];
  assign sub_a     = (state == S_DEC && k != 3'd1) ? prev_stamp : tick;
  assign diff      = sub_a - rdata;
  assign over      = diff > STAMP_W'(stale_limit);
  assign rapid_hit = diff < STAMP_W'(rapid_limit);
  assign rc_inc    = (rapid_cnt[fidx] == '1) ? rapid_cnt[fidx] : rapid_cnt[fidx] + 8'd1;
  assign last_face = (fidx == FACE_W'(FACE_COUNT - 1));

  always_comb begin
    if (stale) begin
      match = '0;
    end else if (gap[0] == gap[1] || gap[0] == gap[2]) begin
      match = gap[0];
    end else if (gap[1] == gap[2]) begin
      match = gap[1];
    end else begin
      match = '0;
    end
  end

  always_comb begin
    rule_ok = 1'b0;
    if (on_cnt < COUNT_W'(RULE_W)) begin
      rule_ok = (tile == '0) ? birth_rules[on_cnt[2:0]] : death_rules[on_cnt[2:0]];
    end
  end

  always_comb begin
    ring_req.we    = (state == S_EDGE) && rise_cur && !rapid_hit;
    ring_req.waddr = ring_addr(fidx, ptr_cur + 2'd1);
    ring_req.wdata = tick;
    ring_req.raddr = ring_addr(fidx, PTR_W'(ptr_cur - k[PTR_W-1:0]));
  end

  assign age_req.start   = (state == S_RULE) && eval_q && (tile != '0) && rule_ok;
  assign age_req.age     = tile;
  assign age_req.modulus = num_states;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_rules <= BIRTH_RESET;
      death_rules <= DEATH_RESET;
      num_states  <= NSTATES_RESET;
      stale_limit <= STALE_RESET;
      rapid_limit <= RAPID_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIRTH:   birth_rules <= cfg_data[RULE_W-1:0];
        REG_DEATH:   death_rules <= cfg_data[RULE_W-1:0];
        REG_NSTATES: num_states  <= cfg_data;
        REG_STALE:   stale_limit <= cfg_data;
        REG_RAPID:   rapid_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tick        <= '0;
      prev_levels <= '0;
      tile        <= '0;
      fidx        <= '0;
      k           <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < FACE_COUNT; i++) begin
        ring_ptr[i]  <= '0;
        rapid_cnt[i] <= '0;
      end
    end else begin
      // S_DONE drives out_valid itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          fidx <= '0;
          k    <= '0;
          if (in_valid) begin
            tick        <= tick + 32'd1;
            rising      <= face_levels & ~prev_levels;
            prev_levels <= face_levels;
            eval_q      <= evaluate;
            on_cnt      <= '0;
            click_acc   <= 1'b0;
            req_acc     <= 1'b0;
            req_face    <= '0;
            for (int i = 0; i < STATE_SLOTS; i++) begin
              fstate[i] <= '0;
            end
            state <= S_EDGE;
          end
        end
        S_RD: begin
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (rise_cur) begin
            if (rapid_hit) begin
              rapid_cnt[fidx] <= rc_inc;
              if (rc_inc == 8'd2) begin
                click_acc <= 1'b1;
              end
              if (rc_inc >= 8'd4) begin
                req_acc  <= 1'b1;
                req_face <= fidx;
              end
            end else begin
              rapid_cnt[fidx] <= '0;
              ring_ptr[fidx]  <= ptr_cur + 2'd1;
            end
          end
          k <= '0;
          if (eval_q) begin
            state <= S_DEC;
          end else if (last_face) begin
            state <= S_RULE;
          end else begin
            fidx  <= fidx + 3'd1;
            state <= S_RD;
          end
        end
        S_DEC: begin
          // capture at step k is the stamp k-1 places behind the newest
          if (k == 3'd1) begin
            stale <= over;
          end else if (k != 3'd0) begin
            stale      <= stale | over;
            gap[2'(k - 3'd2)] <= diff[7:3];
          end
          prev_stamp <= rdata;
          if (k == 3'd4) begin
            k     <= '0;
            state <= S_MATCH;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_MATCH: begin
          fstate[fidx] <= match;
          if (match != '0) begin
            on_cnt <= on_cnt + 4'd1;
          end
          if (last_face) begin
            state <= S_RULE;
          end else begin
            fidx  <= fidx + 3'd1;
            state <= S_RD;
          end
        end
        S_RULE: begin
          if (!eval_q) begin
            state <= S_DONE;
          end else if (tile == '0) begin
            if (rule_ok) begin
              tile <= 8'd1;
            end
            state <= S_DONE;
          end else if (rule_ok) begin
            state <= S_AGE;
          end else begin
            state <= S_DONE;
          end
        end
        S_AGE: begin
          if (age_rsp.done) begin
            tile  <= age_rsp.result;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            click           <= click_acc;
            program_request <= req_acc;
            program_face    <= req_face;
            face0_state     <= fstate[0];
            face1_state     <= fstate[1];
            face2_state     <= fstate[2];
            face3_state     <= fstate[3];
            face4_state     <= fstate[4];
            face5_state     <= fstate[5];
            neighbors_on    <= on_cnt[2:0];
            tile_age        <= tile;
            fidx            <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/npd_checker.sv =====
// Port-level checks for the neighbor pulse period decoder top level.
// Attached by bind to neighbor_pulse_period_decoder_top; uses npd_pkg.
module npd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         click,
  input logic                         program_request,
  input logic [npd_pkg::FACE_W-1:0]   program_face,
  input logic [npd_pkg::FSTATE_W-1:0] face0_state,
  input logic [npd_pkg::FSTATE_W-1:0] face1_state,
  input logic [npd_pkg::FSTATE_W-1:0] face2_state,
  input logic [npd_pkg::FSTATE_W-1:0] face3_state,
  input logic [npd_pkg::FSTATE_W-1:0] face4_state,
  input logic [npd_pkg::FSTATE_W-1:0] face5_state,
  input logic [2:0]                   neighbors_on,
  input logic [npd_pkg::BYTE_W-1:0]   tile_age
);
  import npd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({click, program_request,
      program_face, face0_state, face1_state, face2_state, face3_state,
      face4_state, face5_state, neighbors_on, tile_age}))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after taking a word");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(neighbors_on) == $countones({face0_state != '0,
      face1_state != '0, face2_state != '0, face3_state != '0,
      face4_state != '0, face5_state != '0}))
    else $error("neighbor count disagrees with face states");

  a_face_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !program_request |-> program_face == '0)
    else $error("program face set without a request");

endmodule

bind neighbor_pulse_period_decoder_top npd_checker u_npd_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for neighbor_pulse_period_decoder_top: a tick-level predictor
// checks every output word. Depends on npd_pkg and the decoder RTL.
module tb_top;
  import npd_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic               eval;
  } tick_word_t;

  typedef struct packed {
    logic                               click;
    logic                               prog_req;
    logic [FACE_W-1:0]                  prog_face;
    logic [OUT_FACES-1:0][FSTATE_W-1:0] face_st;
    logic [2:0]                         on_cnt;
    logic [BYTE_W-1:0]                  age;
  } tick_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LEVEL_W-1:0]   face_levels = '0;
  logic                 evaluate = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 click;
  logic                 program_request;
  logic [FACE_W-1:0]    program_face;
  logic [FSTATE_W-1:0]  face0_state, face1_state, face2_state;
  logic [FSTATE_W-1:0]  face3_state, face4_state, face5_state;
  logic [2:0]           neighbors_on;
  logic [BYTE_W-1:0]    tile_age;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index = REG_BIRTH;
  logic [BYTE_W-1:0]    cfg_data = '0;

  neighbor_pulse_period_decoder_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .face_levels     (face_levels),
    .evaluate        (evaluate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .click           (click),
    .program_request (program_request),
    .program_face    (program_face),
    .face0_state     (face0_state),
    .face1_state     (face1_state),
    .face2_state     (face2_state),
    .face3_state     (face3_state),
    .face4_state     (face4_state),
    .face5_state     (face5_state),
    .neighbors_on    (neighbors_on),
    .tile_age        (tile_age),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // predictor state
  logic [STAMP_W-1:0] tick_cnt;
  logic [STAMP_W-1:0] stamp_mem [FACE_COUNT][RING_DEPTH];
  logic [PTR_W-1:0]   slot_ptr [FACE_COUNT];
  logic [BYTE_W-1:0]  rapid_cnt [FACE_COUNT];
  logic [LEVEL_W-1:0] prev_levels;
  logic [BYTE_W-1:0]  tile_q;
  logic [RULE_W-1:0]  birth_mask, death_mask;
  logic [BYTE_W-1:0]  age_mod, stale_max, rapid_max;

  tick_word_t   ticks_to_send [$];
  tick_result_t results_due [$];
  bit           in_fire = 1'b0;
  bit           quiet = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  stall_left = 0;
  int           errors = 0;
  int           n_ticks = 0, n_eval = 0, n_click = 0, n_req = 0, n_lit = 0, n_cfg = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FSTATE_W-1:0] period_of(int f);
    logic [PTR_W-1:0]   p;
    logic [STAMP_W-1:0] g0, g1, g2;
    p = slot_ptr[f];
    if (tick_cnt - stamp_mem[f][p] > 32'(stale_max)) return '0;
    g0 = stamp_mem[f][p] - stamp_mem[f][p - 2'd1];
    g1 = stamp_mem[f][p - 2'd1] - stamp_mem[f][p - 2'd2];
    g2 = stamp_mem[f][p - 2'd2] - stamp_mem[f][p - 2'd3];
    if (g0 > 32'(stale_max) || g1 > 32'(stale_max) || g2 > 32'(stale_max)) return '0;
    g0 = g0 >> 3;
    g1 = g1 >> 3;
    g2 = g2 >> 3;
    if (g0 == g1 || g0 == g2) return g0[FSTATE_W-1:0];
    if (g1 == g2) return g1[FSTATE_W-1:0];
    return '0;
  endfunction

  function automatic tick_result_t decode_tick(logic [LEVEL_W-1:0] lv, logic ev);
    tick_result_t       r;
    logic [LEVEL_W-1:0] rise;
    logic [PTR_W-1:0]   p;
    logic [FSTATE_W-1:0] st;
    int                 on;
    int                 modu;
    r = '0;
    on = 0;
    tick_cnt = tick_cnt + 1;
    rise = lv & ~prev_levels;
    prev_levels = lv;
    for (int f = 0; f < FACE_COUNT; f++) begin
      if (f < LEVEL_W && rise[f]) begin
        p = slot_ptr[f];
        if (tick_cnt - stamp_mem[f][p] < 32'(rapid_max)) begin
          if (rapid_cnt[f] != 8'hFF) rapid_cnt[f] = rapid_cnt[f] + 8'd1;
          if (rapid_cnt[f] == 8'd2) r.click = 1'b1;
          if (rapid_cnt[f] >= 8'd4) begin
            r.prog_req = 1'b1;
            r.prog_face = FACE_W'(f);
          end
        end else begin
          rapid_cnt[f] = '0;
          slot_ptr[f] = p + 2'd1;
          stamp_mem[f][p + 2'd1] = tick_cnt;
        end
      end
    end
    for (int f = 0; f < FACE_COUNT; f++) begin
      st = ev ? period_of(f) : '0;
      if (st != 0) on++;
      if (f < OUT_FACES) r.face_st[f] = st;
    end
    if (ev) begin
      if (tile_q == 0) begin
        if (on < RULE_W && birth_mask[on]) tile_q = 8'd1;
      end else if (on < RULE_W && death_mask[on]) begin
        modu = (age_mod == 0) ? 256 : int'(age_mod);
        tile_q = 8'((int'(tile_q) + 1) % modu);
      end
    end
    r.on_cnt = 3'(on);
    r.age = tile_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_edge
    tick_result_t got, want;
    in_fire = in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          REG_BIRTH:   birth_mask = cfg_data[RULE_W-1:0];
          REG_DEATH:   death_mask = cfg_data[RULE_W-1:0];
          REG_NSTATES: age_mod = cfg_data;
          REG_STALE:   stale_max = cfg_data;
          REG_RAPID:   rapid_max = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("output word with no tick pending");
          errors++;
        end else begin
          want = results_due.pop_front();
          got.face_st[0] = face0_state;
          got.face_st[1] = face1_state;
          got.face_st[2] = face2_state;
          got.face_st[3] = face3_state;
          got.face_st[4] = face4_state;
          got.face_st[5] = face5_state;
          check_field("click", 32'(want.click), 32'(click));
          check_field("program_request", 32'(want.prog_req), 32'(program_request));
          check_field("program_face", 32'(want.prog_face), 32'(program_face));
          for (int f = 0; f < OUT_FACES; f++)
            check_field($sformatf("face%0d_state", f), 32'(want.face_st[f]),
                        32'(got.face_st[f]));
          check_field("neighbors_on", 32'(want.on_cnt), 32'(neighbors_on));
          check_field("tile_age", 32'(want.age), 32'(tile_age));
        end
      end
      if (in_fire) begin
        want = decode_tick(face_levels, evaluate);
        results_due.push_back(want);
        n_ticks++;
        n_eval += evaluate;
        n_click += want.click;
        n_req += want.prog_req;
        for (int f = 0; f < OUT_FACES; f++) n_lit += (want.face_st[f] != 0);
      end
    end
  end

  always @(negedge clk) begin : send_ticks
    tick_word_t w;
    if (in_valid && !in_fire) begin
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (ticks_to_send.size() != 0) begin
      w = ticks_to_send.pop_front();
      in_valid <= 1'b1;
      face_levels <= w.levels;
      evaluate <= w.eval;
      send_gap = idle_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : take_results
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  task automatic push_tick(logic [LEVEL_W-1:0] lv, logic ev);
    ticks_to_send.push_back('{lv, ev});
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] d,
                            logic [BYTE_W-1:0] n, logic [BYTE_W-1:0] s,
                            logic [BYTE_W-1:0] r);
    write_reg(REG_BIRTH, b);
    write_reg(REG_DEATH, d);
    write_reg(REG_NSTATES, n);
    write_reg(REG_STALE, s);
    write_reg(REG_RAPID, r);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (ticks_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // periodic pulse trains per face, with jitter, rapid toggle bursts and noise
  task automatic queue_pulse_ticks(int n_ticks_q, int eval_pct, int lo, int hi);
    int         per [LEVEL_W];
    int         wid [LEVEL_W];
    int         nxt [LEVEL_W];
    int         high_left [LEVEL_W];
    int         toggles [LEVEL_W];
    int         step;
    tick_word_t w;
    for (int f = 0; f < LEVEL_W; f++) begin
      per[f] = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(lo, hi));
      wid[f] = (per[f] < 4) ? 1 : int'($urandom_range(1, per[f] / 2));
      nxt[f] = $urandom_range(0, hi);
      high_left[f] = 0;
      toggles[f] = 0;
    end
    for (int t = 0; t < n_ticks_q; t++) begin
      w = '0;
      for (int f = 0; f < LEVEL_W; f++) begin
        if (toggles[f] != 0) begin
          w.levels[f] = toggles[f][0];
          toggles[f]--;
        end else if (high_left[f] != 0) begin
          w.levels[f] = 1'b1;
          high_left[f]--;
        end else if (per[f] != 0 && t >= nxt[f]) begin
          w.levels[f] = 1'b1;
          high_left[f] = wid[f] - 1;
          step = per[f];
          if ($urandom_range(0, 2) == 0) step = step + int'($urandom_range(0, 12)) - 6;
          nxt[f] = t + ((step > wid[f]) ? step : wid[f] + 1);
          if ($urandom_range(0, 11) == 0) begin
            toggles[f] = 2 * $urandom_range(2, 6);
            high_left[f] = 0;
          end
        end else begin
          w.levels[f] = (per[f] == 0) && ($urandom_range(0, 19) == 0);
        end
      end
      if ($urandom_range(0, 24) == 0) w.levels[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
      if ($urandom_range(0, 39) == 0) w.levels = LEVEL_W'($urandom);
      w.eval = ($urandom_range(0, 99) < eval_pct);
      ticks_to_send.push_back(w);
    end
  endtask

  initial begin : run
    int b, d, n, s, r, lo, hi, items, ev, left, cnt;
    tick_cnt = '0;
    prev_levels = '0;
    tile_q = '0;
    for (int f = 0; f < FACE_COUNT; f++) begin
      slot_ptr[f] = '0;
      rapid_cnt[f] = '0;
      for (int k = 0; k < RING_DEPTH; k++) stamp_mem[f][k] = '0;
    end
    birth_mask = BIRTH_RESET;
    death_mask = DEATH_RESET;
    age_mod = NSTATES_RESET;
    stale_max = STALE_RESET;
    rapid_max = RAPID_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: rapid edges, click, program request on top face
    push_tick(6'h00, 1'b0);
    push_tick(6'h3F, 1'b1);
    push_tick(6'h00, 1'b0);
    push_tick(6'h3F, 1'b0);
    push_tick(6'h00, 1'b1);
    push_tick(6'h3F, 1'b0);
    push_tick(6'h00, 1'b0);
    push_tick(6'h3F, 1'b1);
    push_tick(6'h00, 1'b0);
    push_tick(6'h3F, 1'b0);
    push_tick(6'h2A, 1'b1);
    push_tick(6'h15, 1'b0);
    push_tick(6'h2A, 1'b1);
    push_tick(6'h00, 1'b1);
    push_tick(6'h01, 1'b0);
    push_tick(6'h00, 1'b0);
    push_tick(6'h01, 1'b1);
    push_tick(6'h00, 1'b0);
    push_tick(6'h01, 1'b0);
    push_tick(6'h3F, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph % 3 == 2);
      ev = 30;
      case (ph)
        0: begin
          b = 12; d = 115; n = 2; s = 100; r = 10; lo = 11; hi = 60; items = 250;
        end
        1: begin
          b = 127; d = 127; n = 255; s = 255; r = 255; lo = 8; hi = 90; items = 120;
        end
        2: begin
          b = 0; d = 0; n = 0; s = 0; r = 0; lo = 4; hi = 30; items = 100; ev = 40;
        end
        3: begin
          // age wraps past 255 with a zero modulus
          b = 127; d = 127; n = 0; s = 120; r = 6; lo = 8; hi = 40; items = 280; ev = 95;
        end
        default: begin
          b = $urandom_range(0, 127);
          d = $urandom_range(0, 127);
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
          s = $urandom_range(40, 255);
          r = $urandom_range(2, 16);
          lo = (r + 1 > 8) ? r + 1 : 8;
          hi = (s < 90) ? s : 90;
          items = 170;
        end
      endcase
      set_config(BYTE_W'(b), BYTE_W'(d), BYTE_W'(n), BYTE_W'(s), BYTE_W'(r));
      left = items;
      while (left > 0) begin
        cnt = $urandom_range(40, 160);
        if (cnt > left) cnt = left;
        queue_pulse_ticks(cnt, ev, lo, hi);
        left -= cnt;
      end
      drain();
    end

    $display("Covered %0d ticks (%0d evaluated) over %0d register writes",
             n_ticks, n_eval, n_cfg);
    $display("Checked %0d clicks, %0d program requests, %0d decoded faces",
             n_click, n_req, n_lit);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
